// ===== src/complementary_tilt_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tilt filter
// Shared concurrent assertion forms used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define COMPLEMENTARY_TILT_FILTER_DEFINES_SVH

// Implication checked every clock outside reset.
`define CTF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked every clock outside reset.
`define CTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt filter package
// Widths, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  // CORDIC datapath: 16-bit input scaled by 2^16, growth and a sign bit.
  localparam int CordW = 36;
  localparam int AngW = 32;
  localparam int MulW = 64;
  localparam int MulCntW = 7;

  localparam logic signed [AngW-1:0] Deg90 = 32'sd5898240;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd2949120;
        5'd1: r = 32'sd1740967;
        5'd2: r = 32'sd919879;
        5'd3: r = 32'sd466945;
        5'd4: r = 32'sd234379;
        5'd5: r = 32'sd117304;
        5'd6: r = 32'sd58666;
        5'd7: r = 32'sd29335;
        5'd8: r = 32'sd14668;
        5'd9: r = 32'sd7334;
        5'd10: r = 32'sd3667;
        5'd11: r = 32'sd1833;
        5'd12: r = 32'sd917;
        5'd13: r = 32'sd458;
        5'd14: r = 32'sd229;
        5'd15: r = 32'sd115;
        5'd16: r = 32'sd57;
        5'd17: r = 32'sd29;
        5'd18: r = 32'sd14;
        5'd19: r = 32'sd7;
        5'd20: r = 32'sd4;
        5'd21: r = 32'sd2;
        5'd22: r = 32'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;

endpackage

// ===== src/ctf_cordic.sv =====
// ----------------------------------------------------------------------------
// CORDIC vectoring unit
// Iterative atan2 in degrees Q16.16, one rotation per cycle.
// ----------------------------------------------------------------------------
module ctf_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [15:0]                 y_in,
  input  logic signed [15:0]                 x_in,
  output logic                               busy,
  output logic signed [ctf_pkg::AngW-1:0]    angle
);
  logic signed [ctf_pkg::CordW-1:0] x, y;
  logic signed [ctf_pkg::AngW-1:0]  z;
  logic [ctf_pkg::StepW-1:0]        step;
  logic signed [ctf_pkg::CordW-1:0] xs, ys, xi, yi;

  assign angle = z;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign xi = ctf_pkg::CordW'(x_in) <<< 16;
  assign yi = ctf_pkg::CordW'(y_in) <<< 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= !(x_in == 16'sd0 && y_in == 16'sd0);
      step <= '0;
    end else if (busy) begin
      if (step == ctf_pkg::StepW'(ctf_pkg::CordicSteps - 1)) busy <= 1'b0;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        // Pre-rotate by a quarter turn so the vector lies in the right half.
        if (y_in >= 0) begin
          x <= yi; y <= -xi; z <= ctf_pkg::Deg90;
        end else begin
          x <= -yi; y <= xi; z <= -ctf_pkg::Deg90;
        end
      end else begin
        x <= xi; y <= yi; z <= '0;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys; y <= y - xs; z <= z + ctf_pkg::atan_deg(5'(step));
      end else begin
        x <= x - ys; y <= y + xs; z <= z - ctf_pkg::atan_deg(5'(step));
      end
    end
  end

  `include "complementary_tilt_filter_defines.svh"
  `CTF_ASSERT_NEXT(a_zero_vec, clk, rst, start && x_in == 0 && y_in == 0, !busy && angle == 0)
  `CTF_ASSERT_IMP(a_step_range, clk, rst, busy, step < ctf_pkg::StepW'(ctf_pkg::CordicSteps))
endmodule

// ===== src/ctf_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed 48-bit multiplicand times unsigned 24-bit multiplier, one bit a cycle.
// ----------------------------------------------------------------------------
module ctf_serial_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [47:0]   mcand,
  input  logic [23:0]          mplier,
  output logic                 busy,
  output logic signed [71:0]   product
);
  logic signed [71:0] acc;
  logic signed [71:0] shifted;
  logic [23:0]        bits;
  logic [4:0]         cnt;

  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == 5'd23) busy <= 1'b0;
    end
  end

  // Shift-add: the multiplicand moves left one place per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      shifted <= 72'(mcand);
      bits <= mplier;
    end else if (busy) begin
      if (bits[0]) acc <= acc + shifted;
      shifted <= shifted <<< 1;
      bits <= bits >> 1;
    end
  end
endmodule

// ===== src/complementary_tilt_filter.sv =====
// ----------------------------------------------------------------------------
// Complementary tilt filter
// Blends gyro-integrated roll and pitch with accelerometer CORDIC angles.
// ----------------------------------------------------------------------------
// channel   direction  handshake      payload
// input     in         valid/ready    accel_x..z, rate_x..z
// output    out        out_valid/rdy  roll_out, pitch_out, yaw_out
// config    in         APB            blend_weight (0x0), rate_gain (0x4)
//
// Items do not overlap: each runs three increment multiplies while the two
// 16-step CORDIC passes run beside them, then four blend multiplies, then
// loads the output register before the next item is accepted.
// Reset is synchronous and clears the angles and registers to their defaults.
// A new item is taken while the previous result waits in the output register;
// the filter stalls in S_DONE only while that result is still unread.
module complementary_tilt_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] roll_out,
  output logic signed [31:0] pitch_out,
  output logic signed [31:0] yaw_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam logic [3:0] S_IDLE = 4'd0, S_GO = 4'd1, S_WAIT = 4'd2, S_NEXT = 4'd3,
                         S_BL = 4'd4, S_BLW = 4'd5, S_DONE = 4'd6;
  localparam logic [2:0] AddrWeight = 3'd0, AddrGain = 3'd4;

  logic [3:0]  state;
  logic [16:0] blend_weight;
  logic [23:0] rate_gain;
  logic signed [31:0] roll_angle, pitch_angle, yaw_angle;
  logic signed [31:0] out_roll, out_pitch, out_yaw;
  logic signed [15:0] rx, ry, rz;
  logic [1:0]  phase;
  logic signed [31:0] roll_acc, pitch_acc;
  logic signed [47:0] inc_r, inc_p, g_r;
  logic signed [71:0] sum;
  logic        done_take;

  ctf_pkg::unit_ctl_t cor_ctl, mul_ctl;
  logic cor_r_busy, cor_p_busy;
  logic signed [31:0] ang_r, ang_p;
  logic signed [47:0] m_a;
  logic [23:0] m_b;
  logic signed [71:0] prod;
  logic [16:0] alpha;
  logic signed [72:0] res;

  assign pready = 1'b1;
  assign ready = (state == S_IDLE);
  assign alpha = (blend_weight > 17'd65536) ? 17'd65536 : blend_weight;
  assign done_take = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    unique case (paddr)
      AddrWeight: prdata = 32'(blend_weight);
      AddrGain:   prdata = 32'(rate_gain);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= 17'd62416;
      rate_gain <= 24'd1309439;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrWeight) blend_weight <= pwdata[16:0];
      else if (paddr == AddrGain) rate_gain <= pwdata[23:0];
    end
  end

  assign cor_ctl.start = (state == S_IDLE) && valid;
  assign cor_ctl.busy = cor_r_busy || cor_p_busy;
  assign cor_ctl.done = 1'b0;

  ctf_cordic u_cor_r (.clk, .rst, .start(cor_ctl.start), .y_in(accel_x), .x_in(accel_z),
                      .busy(cor_r_busy), .angle(ang_r));
  ctf_cordic u_cor_p (.clk, .rst, .start(cor_ctl.start), .y_in(accel_y), .x_in(accel_z),
                      .busy(cor_p_busy), .angle(ang_p));

  // Multiplier job per phase: three increments, then blend terms.
  always_comb begin
    m_a = '0;
    m_b = '0;
    if (state == S_BL || state == S_BLW) begin
      unique case (phase)
        2'd0: begin m_a = g_r; m_b = 24'(alpha); end
        2'd1: begin m_a = 48'(roll_acc); m_b = 24'(17'd65536 - alpha); end
        2'd2: begin m_a = inc_p + 48'(pitch_angle); m_b = 24'(alpha); end
        default: begin m_a = -48'(pitch_acc); m_b = 24'(17'd65536 - alpha); end
      endcase
    end else begin
      unique case (phase)
        2'd0: m_a = 48'(rx);
        2'd1: m_a = 48'(ry);
        default: m_a = 48'(rz);
      endcase
      m_b = rate_gain;
    end
  end

  assign mul_ctl.start = (state == S_GO) || (state == S_BL);
  assign mul_ctl.done = 1'b0;
  ctf_serial_mul u_mul (.clk, .rst, .start(mul_ctl.start), .mcand(m_a), .mplier(m_b),
                        .busy(mul_ctl.busy), .product(prod));

  assign res = 73'(sum) + 73'(prod);

  function automatic logic signed [31:0] sat(input logic signed [72:0] v);
    logic signed [56:0] s;
    begin
      s = 57'(v >>> 16);
      if (s > 57'sd2147483647) return 32'h7fffffff;
      if (s < -57'sd2147483648) return 32'h80000000;
      return 32'(s);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      phase <= '0;
      roll_angle <= '0; pitch_angle <= '0; yaw_angle <= '0;
    end else begin
      priority if (done_take) begin
        out_valid <= 1'b1;
        out_roll <= roll_angle; out_pitch <= pitch_angle; out_yaw <= yaw_angle;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (cor_ctl.start) begin
          state <= S_GO; phase <= '0;
          rx <= rate_x; ry <= rate_y; rz <= rate_z;
        end
        S_GO: state <= S_WAIT;
        S_WAIT: if (!mul_ctl.busy) begin
          unique case (phase)
            2'd0: inc_r <= 48'(prod >>> 16);
            2'd1: inc_p <= 48'(prod >>> 16);
            default: yaw_angle <= yaw_angle + 32'(prod >>> 16);
          endcase
          state <= S_NEXT;
        end
        S_NEXT: if (phase == 2'd2) begin
          if (!cor_ctl.busy) begin
            roll_acc <= ang_r; pitch_acc <= ang_p;
            g_r <= inc_r + 48'(roll_angle);
            phase <= '0; state <= S_BL;
          end
        end else begin
          phase <= phase + 1'b1; state <= S_GO;
        end
        S_BL: state <= S_BLW;
        S_BLW: if (!mul_ctl.busy) begin
          unique case (phase)
            2'd0: sum <= prod;
            2'd1: roll_angle <= sat(res);
            2'd2: sum <= prod;
            default: pitch_angle <= sat(res);
          endcase
          if (phase == 2'd3) state <= S_DONE;
          else begin phase <= phase + 1'b1; state <= S_BL; end
        end
        S_DONE: if (done_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign roll_out = out_roll;
  assign pitch_out = out_pitch;
  assign yaw_out = out_yaw;

  `include "complementary_tilt_filter_defines.svh"
  `CTF_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !ready)
  `CTF_ASSERT_NEXT(a_done_valid, clk, rst, state == S_DONE, out_valid)
  `CTF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(roll_out))
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Tilt filter testbench
// Drives raw IMU samples into the tilt filter and checks every roll, pitch
// and yaw result against a cycle-free predictor of the filter, over several
// register settings and several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 300;
  localparam int PhaseItems = 220;
  localparam int RxHoldCycles = 3000;
  localparam logic [2:0] AddrBlendWeight = 3'd0;
  localparam logic [2:0] AddrRateGain = 3'd4;

  localparam longint AtanDegQ16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct {
    logic signed [31:0] roll, pitch, yaw;
  } attitude_t;

  logic clk;
  logic rst;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x, accel_y, accel_z;
  logic signed [15:0] rate_x, rate_y, rate_z;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] roll_out, pitch_out, yaw_out;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  imu_sample_t sample_q[$];
  attitude_t attitude_q[$];

  // Predictor state and register copies.
  logic [16:0] weight_cfg;
  logic [23:0] gain_cfg;
  logic signed [31:0] roll_st = '0, pitch_st = '0, yaw_st = '0;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int fail_count = 0;
  int quiet_cycles;

  complementary_tilt_filter dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint atan2_deg(longint yin, longint xin);
    longint x, y, z, t, xs, ys;
    int steps;
    x = xin * 65536;
    y = yin * 65536;
    z = 0;
    steps = (ctf_pkg::CordicSteps > 32) ? 32 : ctf_pkg::CordicSteps;
    if (xin == 0 && yin == 0) return 0;
    // Vectors in the left half plane are first turned by a quarter.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 65536;
      end else begin
        x = -y;
        y = t;
        z = -90 * 65536;
      end
    end
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += AtanDegQ16[i];
      end else begin
        x -= ys;
        y += xs;
        z -= AtanDegQ16[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [31:0] blend_angle(longint g, longint acc, longint alpha);
    longint r;
    r = (alpha * g + (65536 - alpha) * acc) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_attitude(imu_sample_t s);
    longint alpha, gain, inc_r, inc_p, inc_y;
    attitude_t a;
    alpha = (weight_cfg > 17'd65536) ? 65536 : longint'(weight_cfg);
    gain = longint'(gain_cfg);
    inc_r = (longint'(s.gx) * gain) >>> 16;
    inc_p = (longint'(s.gy) * gain) >>> 16;
    inc_y = (longint'(s.gz) * gain) >>> 16;
    roll_st = blend_angle(longint'(roll_st) + inc_r,
                          atan2_deg(longint'(s.ax), longint'(s.az)), alpha);
    pitch_st = blend_angle(longint'(pitch_st) + inc_p,
                           -atan2_deg(longint'(s.ay), longint'(s.az)), alpha);
    yaw_st = yaw_st + inc_y[31:0];
    a.roll = roll_st;
    a.pitch = pitch_st;
    a.yaw = yaw_st;
    attitude_q.push_back(a);
  endtask

  // Driver: offers queued samples, idling at random between items.
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && ready) begin
        predict_attitude('{accel_x, accel_y, accel_z, rate_x, rate_y, rate_z});
      end
      if (!valid || ready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          valid <= 1'b1;
          accel_x <= sample_q[0].ax;
          accel_y <= sample_q[0].ay;
          accel_z <= sample_q[0].az;
          rate_x <= sample_q[0].gx;
          rate_y <= sample_q[0].gy;
          rate_z <= sample_q[0].gz;
          void'(sample_q.pop_front());
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and stalls the output at random.
  always @(posedge clk) begin
    attitude_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (attitude_q.size() == 0) begin
          $display("%0t: result with none expected: roll %0d pitch %0d yaw %0d",
                   $time, roll_out, pitch_out, yaw_out);
          fail_count++;
        end else begin
          e = attitude_q.pop_front();
          if (roll_out !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_out);
            fail_count++;
          end
          if (pitch_out !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_out);
            fail_count++;
          end
          if (yaw_out !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_out);
            fail_count++;
          end
        end
      end
      if (hold_armed && !hold_done) begin
        hold_done <= 1'b1;
        rx_hold_cycles <= RxHoldCycles;
        out_ready <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
        rx_hold_cycles <= rx_hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrBlendWeight) weight_cfg = data[16:0];
    else if (addr == AddrRateGain) gain_cfg = data[23:0];
  endtask

  task automatic add_sample(int ax, int ay, int az, int gx, int gy, int gz);
    sample_q.push_back('{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)});
  endtask

  function automatic int pick_axis();
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return int'($urandom_range(20)) - 10;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic wait_drained();
    wait (sample_q.size() == 0 && !valid && attitude_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] weights [8];
    logic [31:0] gains [8];
    weights = '{62416, 0, 65536, 131071, $urandom_range(65536), 1, 65535, 32768};
    gains = '{1309439, 0, 24'hFFFFFF, $urandom_range(24'hFFFFFF),
              $urandom_range(24'hFFFFFF), 1, 24'h800000, 1309439};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    weight_cfg = 17'd62416;
    gain_cfg = 24'd1309439;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items at reset settings: the zero vector, each quadrant of
    // both arctangents, negative z with zero or signed numerators, extremes.
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(0, 0, 16384, 0, 0, 0);
    add_sample(16384, -16384, 16384, 100, -100, 100);
    add_sample(16384, 16384, -16384, -100, 100, -100);
    add_sample(-16384, -16384, -16384, 1, -1, 1);
    add_sample(0, 0, -16384, 0, 0, 0);
    add_sample(-1, 1, -1, 0, 0, 0);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    add_sample(32767, -32768, 0, 32767, -32768, 32767);
    add_sample(-32768, 32767, 0, -32768, 32767, -32768);
    add_sample(0, 5, 0, 0, 0, 0);
    add_sample(-7, 0, 0, 0, 0, 0);
    add_sample(1, -1, 32767, 0, 0, 0);
    add_sample(32767, 32767, -32768, 12345, -12345, 31000);
    add_sample(-32768, -32768, 32767, -1, -1, -1);
    add_sample(0, 0, 0, 32767, 32767, 32767);
    add_sample(0, 0, 0, -32768, -32768, -32768);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      reg_write(AddrBlendWeight, weights[p]);
      reg_write(AddrRateGain, gains[p]);
      tx_idle_pct = (p % 4 == 1 || p % 4 == 3) ? 69 : 0;
      rx_idle_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 33 : 0;
      if (p % 4 == 3) tx_idle_pct = 33;
      // A long receiver hold backs the filter up while samples keep coming.
      if (p == 1) hold_armed = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        add_sample(pick_axis(), pick_axis(), pick_axis(),
                   pick_axis(), pick_axis(), pick_axis());
      end
      // Each phase ends with the sender paused until every result is back.
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && attitude_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ctf_pkg.sv
src/ctf_cordic.sv
src/ctf_serial_mul.sv
src/complementary_tilt_filter.sv
verif/testbench.sv
